FILE: rtl/fgcc_pkg.sv
// ----------------------------------------------------------------------------
// fgcc_pkg: shared types and constants of the footprint collision checker
// request payloads, result codes and configuration register indexes
// ----------------------------------------------------------------------------
package fgcc_pkg;

  localparam int unsigned CellAw    = 16;
  localparam int unsigned MaxCells  = 65536;
  localparam int unsigned CellBits  = 8;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [0:0] {
    OP_QUERY = 1'b0,
    OP_WRITE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CAUSE_FREE     = 2'd0,
    CAUSE_OCCUPIED = 2'd1,
    CAUSE_OUTSIDE  = 2'd2,
    CAUSE_ACK      = 2'd3
  } cause_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ORIGIN_X    = 3'd0,
    REG_ORIGIN_Y    = 3'd1,
    REG_CELLS_PER_M = 3'd2,
    REG_GRID_WIDTH  = 3'd3,
    REG_GRID_HEIGHT = 3'd4,
    REG_ROBOT_LEN   = 3'd5,
    REG_ROBOT_WID   = 3'd6,
    REG_MAP_VALID   = 3'd7
  } reg_idx_t;

  localparam logic signed [7:0] OccThreshold = 8'sd50;

  typedef struct packed {
    logic              operation;
    logic [15:0]       cell_index;
    logic signed [7:0] cell_value;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
  } in_item_t;

  typedef struct packed {
    logic       hit;
    logic [1:0] cause;
  } out_item_t;

endpackage

FILE: rtl/fgcc_ram.sv
// ----------------------------------------------------------------------------
// fgcc_ram: generic single-port ram
// one access a cycle, read data registered
// ----------------------------------------------------------------------------
module fgcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/footprint_grid_collision_check_unit.sv
// ----------------------------------------------------------------------------
// footprint_grid_collision_check_unit: rectangle footprint against occupancy grid
// rotates the four robot corners by the pose yaw and checks, until a hit, each corner's grid cell
// ----------------------------------------------------------------------------
//  channel | direction | handshake      | payload
//  in_     | request   | valid / stall  | in_item_t
//  out_    | result    | valid / stall  | out_item_t
//  cfg_    | write     | we             | idx, data
//
// a cell write, or a query with no map, steps through request and ack; a query
// steps through request, squares and rotation terms, then through multiply,
// scale, address and memory read for each corner checked, ending at address
// for a corner off the grid; the corners share the single grid memory port.
// reset is synchronous on rst_n and clears control and configuration only.
// a finished result waits in the output register; the next request is taken
// in the same cycle that result is taken.
module footprint_grid_collision_check_unit
  import fgcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_item_t           out_data,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_data
);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_TRIG  = 8'b0000_0010,
    ST_ROT   = 8'b0000_0100,
    ST_MUL   = 8'b0000_1000,
    ST_SCALE = 8'b0001_0000,
    ST_ADDR  = 8'b0010_0000,
    ST_READ  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic signed [31:0] origin_x_r, origin_y_r;
  logic [23:0]        cpm_r;
  logic [12:0]        gw_r, gh_r;
  logic [20:0]        rlen_r, rwid_r;
  logic               map_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= '0;
      origin_y_r  <= '0;
      cpm_r       <= 24'd1310720;
      gw_r        <= '0;
      gh_r        <= '0;
      rlen_r      <= 21'd39322;
      rwid_r      <= 21'd39322;
      map_valid_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_ORIGIN_X:    origin_x_r  <= cfg_data;
        REG_ORIGIN_Y:    origin_y_r  <= cfg_data;
        REG_CELLS_PER_M: cpm_r       <= cfg_data[23:0];
        REG_GRID_WIDTH:  gw_r        <= cfg_data[12:0];
        REG_GRID_HEIGHT: gh_r        <= cfg_data[12:0];
        REG_ROBOT_LEN:   rlen_r      <= cfg_data[20:0];
        REG_ROBOT_WID:   rwid_r      <= cfg_data[20:0];
        REG_MAP_VALID:   map_valid_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request hold registers
  in_item_t           req_r;
  logic signed [32:0] px_r, py_r;
  logic signed [33:0] c_r, s_r;
  logic signed [31:0] zz_r, ww_r, wz_r;
  logic [1:0]         k_r;
  logic signed [55:0] ax_r, bx_r, ay_r, by_r;
  logic signed [59:0] colp_r, rowp_r;
  out_item_t          out_r;
  logic               out_valid_r;

  logic accept;
  logic out_free;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // corner signs
  logic signed [21:0] lx, ly;
  assign lx = k_r[1] ? $signed({1'b0, rlen_r}) : -$signed({1'b0, rlen_r});
  assign ly = k_r[0] ? $signed({1'b0, rwid_r}) : -$signed({1'b0, rwid_r});

  // corner position in 2^-45 m, then floor to Q16.16
  logic signed [63:0] dx, dy;
  assign dx = (64'(px_r) <<< 29) + 64'(ax_r) - 64'(bx_r);
  assign dy = (64'(py_r) <<< 29) + 64'(ay_r) + 64'(by_r);

  // scaled cell coordinates, floor by 2^32
  logic signed [27:0] col, row;
  assign col = colp_r[59:32];
  assign row = rowp_r[59:32];

  logic signed [41:0] lin;
  assign lin = 42'(row) * $signed({1'b0, gw_r}) + 42'(col);

  // off-grid test and cell address share the address cycle
  logic outside;
  assign outside = col < 0 || col >= $signed({15'd0, gw_r}) || row < 0 ||
                   row >= $signed({15'd0, gh_r}) || lin >= 42'sd65536;

  // memory port
  logic             ram_we;
  logic [CellAw-1:0] ram_addr;
  logic [7:0]       ram_rdata;
  assign ram_we   = accept && (in_data.operation == OP_WRITE);
  assign ram_addr = ram_we ? in_data.cell_index : lin[CellAw-1:0];

  fgcc_ram #(.Width(CellBits), .Depth(MaxCells)) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_data.cell_value),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept) begin
        state_nxt = (in_data.operation == OP_WRITE || !map_valid_r) ? ST_DONE : ST_TRIG;
      end
      ST_TRIG:  state_nxt = ST_ROT;
      ST_ROT:   state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_SCALE;
      ST_SCALE: state_nxt = ST_ADDR;
      ST_ADDR:  state_nxt = outside ? ST_IDLE : ST_READ;
      ST_READ:  begin
        if ($signed(ram_rdata) >= OccThreshold || k_r == 2'd3) state_nxt = ST_IDLE;
        else state_nxt = ST_MUL;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (state_r == ST_DONE ||
          (state_r == ST_ADDR && outside) || state_r == ST_READ &&
          ($signed(ram_rdata) >= OccThreshold || k_r == 2'd3)) begin
        out_valid_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (accept) begin
        req_r <= in_data;
        px_r  <= 33'(in_data.pose_x) - 33'(origin_x_r);
        py_r  <= 33'(in_data.pose_y) - 33'(origin_y_r);
        k_r   <= 2'd0;
      end
      ST_TRIG: begin
        zz_r <= req_r.quat_z * req_r.quat_z;
        ww_r <= req_r.quat_w * req_r.quat_w;
        wz_r <= req_r.quat_w * req_r.quat_z;
      end
      ST_ROT: begin
        c_r <= 34'(ww_r) - 34'(zz_r);
        s_r <= 34'(wz_r) <<< 1;
      end
      ST_MUL: begin
        ax_r <= 56'(c_r) * 56'(lx);
        bx_r <= 56'(s_r) * 56'(ly);
        ay_r <= 56'(s_r) * 56'(lx);
        by_r <= 56'(c_r) * 56'(ly);
      end
      ST_SCALE: begin
        colp_r <= 60'(dx >>> 29) * $signed({36'd0, cpm_r});
        rowp_r <= 60'(dy >>> 29) * $signed({36'd0, cpm_r});
      end
      ST_READ: k_r <= k_r + 2'd1;
      default: ;
    endcase
    if (state_r == ST_DONE) begin
      out_r.hit   <= 1'b0;
      out_r.cause <= CAUSE_ACK;
    end
    if (state_r == ST_ADDR && outside) begin
      out_r.hit   <= 1'b1;
      out_r.cause <= CAUSE_OUTSIDE;
    end
    if (state_r == ST_READ) begin
      if ($signed(ram_rdata) >= OccThreshold) begin
        out_r.hit <= 1'b1; out_r.cause <= CAUSE_OCCUPIED;
      end else begin
        out_r.hit <= 1'b0; out_r.cause <= CAUSE_FREE;
      end
    end
  end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: footprint grid collision checker testbench
// cell writes and pose queries are sent through the request channel, results
// are compared with an in-bench prediction of the corner and cell checks
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fgcc_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  footprint_grid_collision_check_unit u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .out_valid, .out_stall, .out_data, .cfg_we, .cfg_idx, .cfg_data
  );

  always #6 clk = ~clk;

  // predictor copy of configuration and grid
  logic signed [31:0] org_x, org_y;
  logic [23:0] cpm;
  logic [12:0] gw, gh;
  logic [20:0] rlen, rwid;
  logic mapv;
  logic signed [7:0] grid [MaxCells];
  bit written [MaxCells];

  in_item_t pending_reqs[$];
  out_item_t expected_results[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit hold_go = 1'b0;
  bit holding = 1'b0;
  int in_gap = 0, out_gap = 0;

  function automatic longint floor_div2(longint v, int n);
    if (v >= 0) return v >>> n;
    return -((-v - 1) >>> n) - 1;
  endfunction

  function automatic longint cell_of(longint m);
    return floor_div2(m * longint'(cpm), 32);
  endfunction

  // corner check for one request, also updates the grid on writes
  function automatic out_item_t predict_collision(in_item_t r);
    out_item_t o;
    longint px, py, qz, qw, cs, sn, lx, ly, dx, dy, col, row, addr;
    o.hit = 1'b0;
    o.cause = CAUSE_ACK;
    if (r.operation == OP_WRITE) begin
      grid[r.cell_index] = r.cell_value;
      written[r.cell_index] = 1;
      return o;
    end
    if (!mapv) return o;
    px = longint'(r.pose_x) - longint'(org_x);
    py = longint'(r.pose_y) - longint'(org_y);
    qz = longint'(r.quat_z);
    qw = longint'(r.quat_w);
    cs = qw * qw - qz * qz;
    sn = 2 * qw * qz;
    for (int k = 0; k < 4; k++) begin
      lx = (k & 2) ? longint'(rlen) : -longint'(rlen);
      ly = (k & 1) ? longint'(rwid) : -longint'(rwid);
      dx = px * (64'sd1 <<< 29) + cs * lx - sn * ly;
      dy = py * (64'sd1 <<< 29) + sn * lx + cs * ly;
      col = cell_of(floor_div2(dx, 29));
      row = cell_of(floor_div2(dy, 29));
      if (col < 0 || col >= gw || row < 0 || row >= gh) begin
        o.hit = 1'b1; o.cause = CAUSE_OUTSIDE; return o;
      end
      addr = row * gw + col;
      if (addr >= MaxCells) begin
        o.hit = 1'b1; o.cause = CAUSE_OUTSIDE; return o;
      end
      if (grid[addr] >= OccThreshold) begin
        o.hit = 1'b1; o.cause = CAUSE_OCCUPIED; return o;
      end
    end
    o.cause = CAUSE_FREE;
    return o;
  endfunction

  // true with no map, or if every corner checked lands on a written cell until one leaves the grid or is occupied
  function automatic bit query_safe(in_item_t r);
    longint px, py, qz, qw, cs, sn, lx, ly, dx, dy, col, row, addr;
    if (!mapv) return 1;
    px = longint'(r.pose_x) - longint'(org_x);
    py = longint'(r.pose_y) - longint'(org_y);
    qz = longint'(r.quat_z);
    qw = longint'(r.quat_w);
    cs = qw * qw - qz * qz;
    sn = 2 * qw * qz;
    for (int k = 0; k < 4; k++) begin
      lx = (k & 2) ? longint'(rlen) : -longint'(rlen);
      ly = (k & 1) ? longint'(rwid) : -longint'(rwid);
      dx = px * (64'sd1 <<< 29) + cs * lx - sn * ly;
      dy = py * (64'sd1 <<< 29) + sn * lx + cs * ly;
      col = cell_of(floor_div2(dx, 29));
      row = cell_of(floor_div2(dy, 29));
      if (col < 0 || col >= gw || row < 0 || row >= gh) return 1;
      addr = row * gw + col;
      if (addr >= MaxCells) return 1;
      if (!written[addr]) return 0;
      if (grid[addr] >= OccThreshold) return 1;
    end
    return 1;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_results.insert(expected_results.size(),
                                predict_collision(pending_reqs.pop_front()));
        in_gap = $urandom_range(0, 4);
      end
      if (in_valid && in_stall) begin
        // hold the offered request
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        in_valid <= 1'b1;
        in_data <= pending_reqs[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off to fill the block
  initial begin
    wait (hold_go);
    holding = 1'b1;
    repeat (200) @(posedge clk);
    holding = 1'b0;
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else if (out_data !== expected_results[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p got %p", expected_results[0], out_data);
          void'(expected_results.pop_front());
        end else begin
          void'(expected_results.pop_front());
        end
        out_gap = $urandom_range(0, 4);
      end
      if (holding) begin
        out_stall <= 1'b1;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    unique case (idx)
      REG_ORIGIN_X:    org_x = val;
      REG_ORIGIN_Y:    org_y = val;
      REG_CELLS_PER_M: cpm = val[23:0];
      REG_GRID_WIDTH:  gw = val[12:0];
      REG_GRID_HEIGHT: gh = val[12:0];
      REG_ROBOT_LEN:   rlen = val[20:0];
      REG_ROBOT_WID:   rwid = val[20:0];
      REG_MAP_VALID:   mapv = val[0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic in_item_t cell_write(int idx, int val);
    in_item_t r;
    r = '0;
    r.operation = OP_WRITE;
    r.cell_index = 16'(idx);
    r.cell_value = 8'(val);
    r.pose_x = $urandom;
    r.pose_y = $urandom;
    r.quat_z = 16'($urandom);
    r.quat_w = 16'($urandom);
    return r;
  endfunction

  // pose near the grid origin, in metres as Q16.16, or a random pose when wild
  function automatic in_item_t pose_query(bit wild);
    in_item_t r;
    int ang;
    r = '0;
    r.operation = OP_QUERY;
    r.cell_index = 16'($urandom);
    r.cell_value = 8'($urandom);
    if (wild) begin
      r.pose_x = $urandom;
      r.pose_y = $urandom;
      r.quat_z = 16'($urandom_range(0, 32768) - 16384);
      r.quat_w = 16'($urandom_range(0, 32768) - 16384);
    end else begin
      r.pose_x = org_x + $signed($urandom_range(0, 9 << 16)) - (1 << 16);
      r.pose_y = org_y + $signed($urandom_range(0, 9 << 16)) - (1 << 16);
      ang = $urandom_range(0, 3);
      r.quat_z = (ang == 0) ? 16'sd0 : 16'($urandom_range(0, 32768) - 16384);
      r.quat_w = (ang == 1) ? 16'sd0 : 16'($urandom_range(0, 32768) - 16384);
    end
    return r;
  endfunction

  // fills the first cells of the grid, then sends queries that read only written cells, mixed with random cell writes
  task automatic run_phase(int n_fill, int n_queries, int wild_pct);
    in_item_t q;
    int sent;
    for (int i = 0; i < gw * gh && i < n_fill; i++)
      pending_reqs.insert(pending_reqs.size(), cell_write(i, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(50, 127) : $urandom_range(0, 177) - 128));
    drain();
    sent = 0;
    while (sent < n_queries) begin
      if ($urandom_range(0, 9) == 0) begin
        pending_reqs.insert(pending_reqs.size(),
                            cell_write($urandom_range(0, gw * gh - 1),
                                       $urandom_range(0, 255)));
        sent++;
      end else begin
        q = pose_query($urandom_range(0, 99) < wild_pct);
        if (query_safe(q)) begin
          pending_reqs.insert(pending_reqs.size(), q);
          sent++;
        end
      end
    end
    drain();
  endtask

  initial begin
    in_item_t q;
    org_x = 0; org_y = 0; cpm = 24'd1310720; gw = 0; gh = 0;
    rlen = 21'd39322; rwid = 21'd39322; mapv = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no map and empty grid cases, extremes of pose fields
    q = pose_query(1); q.pose_x = 32'sh7fffffff; q.quat_z = 16'sd16384;
    q.quat_w = -16'sd16384;
    pending_reqs.insert(pending_reqs.size(), q);
    q = pose_query(1); q.pose_x = 32'sh80000000; q.pose_y = 32'sh80000000;
    q.quat_z = -16'sd16384; q.quat_w = 16'sd16384;
    pending_reqs.insert(pending_reqs.size(), q);
    pending_reqs.insert(pending_reqs.size(), cell_write(16'hffff, -128));
    pending_reqs.insert(pending_reqs.size(), cell_write(0, 127));
    drain();
    write_reg(REG_MAP_VALID, 1);
    pending_reqs.insert(pending_reqs.size(), pose_query(1));
    pending_reqs.insert(pending_reqs.size(), pose_query(0));
    drain();

    // small grid, 1 m cells, 10x10
    write_reg(REG_CELLS_PER_M, 32'h10000);
    write_reg(REG_GRID_WIDTH, 10);
    write_reg(REG_GRID_HEIGHT, 10);
    write_reg(REG_ROBOT_LEN, 32'h8000);
    write_reg(REG_ROBOT_WID, 32'h4000);
    // directed: unknown cell and a cell just under the threshold
    pending_reqs.insert(pending_reqs.size(), cell_write(55, -1));
    pending_reqs.insert(pending_reqs.size(), cell_write(44, 49));
    run_phase(100, 300, 10);

    // long receiver hold-off to fill the block
    hold_go = 1'b1;
    run_phase(100, 150, 10);

    // shifted origin, finer cells, zero robot length
    write_reg(REG_ORIGIN_X, 32'hfffb0000);
    write_reg(REG_ORIGIN_Y, 32'h00030000);
    write_reg(REG_CELLS_PER_M, 32'h20000);
    write_reg(REG_GRID_WIDTH, 18);
    write_reg(REG_GRID_HEIGHT, 18);
    write_reg(REG_ROBOT_LEN, 0);
    write_reg(REG_ROBOT_WID, 32'h100000);
    run_phase(324, 250, 10);

    // extremes: max scale, wide grid, large footprint
    write_reg(REG_CELLS_PER_M, 32'hffffff);
    write_reg(REG_GRID_WIDTH, 4096);
    write_reg(REG_GRID_HEIGHT, 16);
    write_reg(REG_ROBOT_LEN, 32'h100000);
    write_reg(REG_ORIGIN_X, 32'h7fff0000);
    write_reg(REG_ORIGIN_Y, 32'h80000000);
    run_phase(100, 150, 30);

    // smallest scale, tall single column
    write_reg(REG_CELLS_PER_M, 1);
    write_reg(REG_GRID_WIDTH, 1);
    write_reg(REG_GRID_HEIGHT, 4096);
    write_reg(REG_ORIGIN_X, 0);
    write_reg(REG_ORIGIN_Y, 0);
    run_phase(100, 100, 50);

    write_reg(REG_MAP_VALID, 0);
    run_phase(0, 70, 50);

    if (mismatches == 0 && expected_results.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
